// ----- rtl/core/twosm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Omni speed mixer package
// Shared widths, CORDIC constants and the stage payload types.
// ----------------------------------------------------------------------------
package twosm_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int XY_W   = 32;   // CORDIC x/y, Q30
  localparam int Z_W    = 32;   // residual angle, 2^-32 turn
  localparam int PR_W   = 28;   // speed_fraction * speed_limit
  localparam int ROT_W  = 28;   // spin * speed_limit
  localparam int CS_W   = 18;   // cos/sin, Q16
  localparam int XQ_W   = 47;   // pr * cos
  localparam int M_W    = 36;   // sin * sin60
  localparam int MH_W   = 18;   // upper slice of M
  localparam int ML_W   = M_W - MH_W;
  localparam int SUM_W  = 64;   // wheel sums, 2^-(FRAC_BITS+32) steps/s
  localparam int WS_W   = 13;   // wheel speed output
  localparam int RS_W   = 12;   // speed_limit

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [CS_W-1:0] SIN60_Q16   = 18'sd56756;
  localparam logic signed [32:0]     COS_HALF    = 33'sd8192;

  localparam logic [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  // Payload handed from cell to cell along the CORDIC chain
  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic [1:0]              quad;
    logic [PR_W-1:0]         pr;
    logic signed [ROT_W-1:0] rot;
  } cordic_t;

  // Exact wheel sums before clamp and rounding
  typedef struct packed {
    logic signed [SUM_W-1:0] w0;
    logic signed [SUM_W-1:0] w1;
    logic signed [SUM_W-1:0] w2;
  } sums_t;

endpackage

// ----- rtl/core/twosm_cordic_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One micro-rotation of the heading, registered, with its own transfer
// handshake toward the next cell.
// ----------------------------------------------------------------------------
module twosm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  twosm_pkg::cordic_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output twosm_pkg::cordic_t out_data
);
  import twosm_pkg::*;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  ang;
  cordic_t                data_next;

  assign in_ready = !out_valid || out_ready;
  assign ang      = $signed(ATAN_TURNS[STEP]);

  always_comb begin
    dx        = in_data.y >>> STEP;
    dy        = in_data.x >>> STEP;
    data_next = in_data;
    // rotate toward zero residual
    if (!in_data.z[Z_W-1]) begin
      data_next.x = in_data.x - dx;
      data_next.y = in_data.y + dy;
      data_next.z = in_data.z - ang;
    end else begin
      data_next.x = in_data.x + dx;
      data_next.y = in_data.y - dy;
      data_next.z = in_data.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/core/twosm_mix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel mixer pipeline
// Quadrant fold and rounding of cos/sin, scaling multiplies and the
// three-wheel sums, five registered stages.
// ----------------------------------------------------------------------------
module twosm_mix (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  twosm_pkg::cordic_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output twosm_pkg::sums_t   out_data
);
  import twosm_pkg::*;

  localparam int NSTG = 5;
  localparam int PL_W = PR_W + ML_W;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] vld_in;

  // stage A: folded, rounded cos/sin
  logic signed [XY_W-1:0]  cx;
  logic signed [XY_W-1:0]  sy;
  logic signed [CS_W-1:0]  a_c;
  logic signed [CS_W-1:0]  a_s;
  logic [PR_W-1:0]         a_pr;
  logic signed [ROT_W-1:0] a_rot;
  // stage B: first products
  logic signed [XQ_W-1:0]  b_xq;
  logic signed [M_W-1:0]   b_m;
  logic [PR_W-1:0]         b_pr;
  logic signed [ROT_W-1:0] b_rot;
  // stage C: split product and partial sums
  logic signed [XQ_W-1:0]       c_ph;
  logic [PR_W+ML_W-1:0]         c_pl;
  logic signed [SUM_W-1:0]      c_a0;
  logic signed [SUM_W-1:0]      c_a1;
  // stage D: sin60 * y term
  logic signed [SUM_W-1:0] d_ym;
  logic signed [SUM_W-1:0] d_a0;
  logic signed [SUM_W-1:0] d_a1;

  logic signed [SUM_W-1:0] b_xq_w;
  logic signed [SUM_W-1:0] b_rot_w;

  assign rdy[NSTG] = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = vld[NSTG-1];
  assign vld_in    = {vld[NSTG-2:0], in_valid};

  for (genvar i = 0; i < NSTG; i++) begin : g_ctl
    assign rdy[i] = !vld[i] || rdy[i+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= vld_in[i];
      end
    end
  end

  always_comb begin
    case (in_data.quad)
      2'd0: begin
        cx = in_data.x;
        sy = in_data.y;
      end
      2'd1: begin
        cx = -in_data.y;
        sy = in_data.x;
      end
      2'd2: begin
        cx = -in_data.x;
        sy = -in_data.y;
      end
      default: begin
        cx = in_data.y;
        sy = -in_data.x;
      end
    endcase
  end

  assign b_xq_w  = SUM_W'(b_xq);
  assign b_rot_w = SUM_W'(b_rot);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_c   <= CS_W'((33'(cx) + COS_HALF) >>> 14);
      a_s   <= CS_W'((33'(sy) + COS_HALF) >>> 14);
      a_pr  <= in_data.pr;
      a_rot <= in_data.rot;
    end
    if (rdy[1]) begin
      b_xq  <= XQ_W'($signed({1'b0, a_pr})) * XQ_W'(a_c);
      b_m   <= M_W'(a_s) * M_W'(SIN60_Q16);
      b_pr  <= a_pr;
      b_rot <= a_rot;
    end
    if (rdy[2]) begin
      c_ph <= XQ_W'($signed({1'b0, b_pr})) * XQ_W'($signed(b_m[M_W-1:ML_W]));
      c_pl <= PL_W'(b_pr) * PL_W'(b_m[ML_W-1:0]);
      c_a0 <= (b_xq_w <<< 16) + (b_rot_w <<< 32);
      c_a1 <= (b_rot_w <<< 32) - (b_xq_w <<< 15);
    end
    if (rdy[3]) begin
      d_ym <= (SUM_W'(c_ph) <<< ML_W) + $signed(SUM_W'(c_pl));
      d_a0 <= c_a0;
      d_a1 <= c_a1;
    end
    if (rdy[4]) begin
      out_data.w0 <= d_a0;
      out_data.w1 <= d_a1 - d_ym;
      out_data.w2 <= d_a1 + d_ym;
    end
  end

endmodule

// ----- rtl/core/twosm_wheel_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel output stage
// Clamps each wheel sum to the top speed, rounds half up and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module twosm_wheel_out #(
  parameter int FRAC_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [twosm_pkg::RS_W-1:0]   speed_limit,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  twosm_pkg::sums_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [twosm_pkg::WS_W-1:0] wheel_one_speed,
  output logic signed [twosm_pkg::WS_W-1:0] wheel_two_speed,
  output logic signed [twosm_pkg::WS_W-1:0] wheel_three_speed,
  output logic [2:0]                   clamped_mask
);
  import twosm_pkg::*;

  localparam int P = FRAC_BITS + 32;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (P - 1);

  logic signed [SUM_W-1:0] w [3];
  logic [WS_W:0]           fin [3];

  // {hit, speed}
  function automatic logic [WS_W:0] finish(input logic signed [SUM_W-1:0] v,
                                           input logic [RS_W-1:0] lim);
    logic signed [SUM_W-1:0] q;
    logic signed [SUM_W-1:0] lw;
    logic signed [SUM_W-1:0] rnd;
    logic                    rem;
    q   = v >>> P;
    lw  = $signed(SUM_W'(lim));
    rem = |v[P-1:0];
    rnd = (v + HALF) >>> P;
    if (q > lw || (q == lw && rem)) begin
      return {1'b1, WS_W'(lw)};
    end else if (q < -lw) begin
      return {1'b1, WS_W'(-lw)};
    end
    return {1'b0, WS_W'(rnd)};
  endfunction

  assign w[0]     = in_data.w0;
  assign w[1]     = in_data.w1;
  assign w[2]     = in_data.w2;
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      fin[j] = finish(w[j], speed_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      wheel_one_speed   <= $signed(fin[0][WS_W-1:0]);
      wheel_two_speed   <= $signed(fin[1][WS_W-1:0]);
      wheel_three_speed <= $signed(fin[2][WS_W-1:0]);
      clamped_mask      <= {fin[2][WS_W], fin[1][WS_W], fin[0][WS_W]};
    end
  end

endmodule

// ----- rtl/core/three_wheel_omni_speed_mix_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wheel omni speed mixer
// Joystick command to three wheel speeds with clamp flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) transfers one command: speed_fraction,
//   heading (full turn = 65536) and signed spin. Output channel
//   (out_valid/out_ready) transfers the three wheel speeds in steps/s and
//   clamped_mask, one result per command, in command order.
//   cfg_wen writes cfg_wdata into speed_limit (top speed and clamp limit) at
//   the clock edge; write it only while no command is in flight.
//   The pipeline holds one input stage, 30 CORDIC cells, five mixer stages
//   and the output register. Throughput is one command per cycle unless the
//   receiver stalls; every stage has its own valid bit, so bubbles close up.
//   When the receiver stalls, the output register holds its result and the
//   stages behind it keep filling; in_ready drops only once all 37 stages
//   hold a command.
//   Reset empties the pipeline and sets speed_limit to 1000.
// ----------------------------------------------------------------------------
module three_wheel_omni_speed_mix_unit #(
  parameter int FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [11:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        speed_fraction,
  input  logic [15:0]        heading,
  input  logic signed [15:0] spin,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [12:0] wheel_one_speed,
  output logic signed [12:0] wheel_two_speed,
  output logic signed [12:0] wheel_three_speed,
  output logic [2:0]         clamped_mask
);
  import twosm_pkg::*;

  localparam logic [RS_W-1:0] LIMIT_RST = 12'd1000;

  logic [RS_W-1:0]         speed_limit;
  logic [CORDIC_STEPS:0]   c_vld;
  logic [CORDIC_STEPS:0]   c_rdy;
  cordic_t                 c_dat [CORDIC_STEPS+1];
  cordic_t                 prep_next;
  logic [15:0]             hk;
  logic [1:0]              quad;
  logic [15:0]             resid;
  logic                    mix_vld;
  logic                    mix_rdy;
  sums_t                   mix_dat;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= LIMIT_RST;
    end else if (cfg_wen) begin
      speed_limit <= cfg_wdata;
    end
  end

  // nearest quadrant and residual within one eighth of a turn
  assign hk    = heading + 16'h2000;
  assign quad  = hk[15:14];
  assign resid = heading - {quad, 14'd0};

  always_comb begin
    prep_next.x    = CORDIC_GAIN;
    prep_next.y    = '0;
    prep_next.z    = $signed({resid, 16'd0});
    prep_next.quad = quad;
    prep_next.pr   = PR_W'(speed_fraction) * PR_W'(speed_limit);
    prep_next.rot  = ROT_W'(spin) * ROT_W'($signed({1'b0, speed_limit}));
  end

  assign in_ready = !c_vld[0] || c_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld[0] <= 1'b0;
    end else if (in_ready) begin
      c_vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      c_dat[0] <= prep_next;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    twosm_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_vld[i]),
      .in_ready  (c_rdy[i]),
      .in_data   (c_dat[i]),
      .out_valid (c_vld[i+1]),
      .out_ready (c_rdy[i+1]),
      .out_data  (c_dat[i+1])
    );
  end

  twosm_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_vld[CORDIC_STEPS]),
    .in_ready  (c_rdy[CORDIC_STEPS]),
    .in_data   (c_dat[CORDIC_STEPS]),
    .out_valid (mix_vld),
    .out_ready (mix_rdy),
    .out_data  (mix_dat)
  );

  twosm_wheel_out #(
    .FRAC_BITS(FRAC_BITS)
  ) u_out (
    .clk               (clk),
    .rst               (rst),
    .speed_limit       (speed_limit),
    .in_valid          (mix_vld),
    .in_ready          (mix_rdy),
    .in_data           (mix_dat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .wheel_one_speed   (wheel_one_speed),
    .wheel_two_speed   (wheel_two_speed),
    .wheel_three_speed (wheel_three_speed),
    .clamped_mask      (clamped_mask)
  );

`ifndef SYNTHESIS
  a_clamp_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamped_mask[0] |->
      (wheel_one_speed == $signed({1'b0, speed_limit}) ||
       wheel_one_speed == -$signed({1'b0, speed_limit})))
    else $error("clamped wheel one not at the limit");

  a_within_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (wheel_two_speed <= $signed({1'b0, speed_limit}) &&
       wheel_two_speed >= -$signed({1'b0, speed_limit})))
    else $error("wheel two beyond the limit");

  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && speed_limit == '0 |->
      (wheel_three_speed == '0 && clamped_mask == '0))
    else $error("nonzero output with zero top speed");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled while output register empty");
`endif

endmodule

// ----- tb/three_wheel_omni_speed_mix_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Omni speed mixer testbench
// Drives joystick commands through the valid/ready input channel and checks
// every wheel speed set and clamp mask against a local fixed-point predictor.
// Runs directed corner cases at several top speeds, then random traffic with
// random gaps and receiver stalls.
// ----------------------------------------------------------------------------
module three_wheel_omni_speed_mix_unit_test;

  localparam int FRAC           = 15;
  localparam int SUM_SHIFT      = FRAC + 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 48;

  // Arctangent of 2^-i in 2^-32 turns
  localparam longint ARC_TURN [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465,  10679838,  5340245,   2670163,  1335087,
    667544,    333772,    166886,    83443,    41722,
    20861,     10430,     5215,      2608,     1304,
    652,       326,       163,       81,       41,
    20,        10,        5,         3,        1
  };

  typedef struct {
    logic [15:0]        sf;
    logic [15:0]        hd;
    logic signed [15:0] sp;
    logic signed [12:0] one;
    logic signed [12:0] two;
    logic signed [12:0] three;
    logic [2:0]         mask;
  } wheel_set_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wen;
  logic [11:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        speed_fraction;
  logic [15:0]        heading;
  logic signed [15:0] spin;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [12:0] wheel_one_speed;
  logic signed [12:0] wheel_two_speed;
  logic signed [12:0] wheel_three_speed;
  logic [2:0]         clamped_mask;

  wheel_set_t  pending_wheels[$];
  wheel_set_t  want;
  logic [11:0] top_speed = 12'd1000;
  int          error_count = 0;
  int          result_count = 0;
  int          quiet_cycles = 0;
  int          sink_hold = 0;
  bit          gaps_on = 1'b1;

  three_wheel_omni_speed_mix_unit i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_wen           (cfg_wen),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .speed_fraction    (speed_fraction),
    .heading           (heading),
    .spin              (spin),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .wheel_one_speed   (wheel_one_speed),
    .wheel_two_speed   (wheel_two_speed),
    .wheel_three_speed (wheel_three_speed),
    .clamped_mask      (clamped_mask)
  );

  always #4 clk = ~clk;

  // Mostly zero, some short, a few long
  function automatic int next_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Q16 cosine and sine of a 16-bit turn fraction
  function automatic void turn_to_cos_sin(input logic [15:0] hd, output longint c,
                                          output longint s);
    logic [31:0] angle;
    logic [31:0] biased;
    logic [31:0] residual;
    logic [1:0]  quad;
    longint      x, y, z, dx, dy, cx, sy;
    angle    = {hd, 16'h0000};
    biased   = angle + 32'h2000_0000;
    quad     = biased[31:30];
    residual = angle - {quad, 30'd0};
    z        = longint'($signed(residual));
    x        = 652032874;
    y        = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARC_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARC_TURN[i];
      end
    end
    case (quad)
      2'd0: begin cx = x;  sy = y;  end
      2'd1: begin cx = -y; sy = x;  end
      2'd2: begin cx = -x; sy = -y; end
      default: begin cx = y; sy = -x; end
    endcase
    c = (cx + 8192) >>> 14;
    s = (sy + 8192) >>> 14;
  endfunction

  // Clamp to +-lim on the exact value, otherwise round half up
  function automatic logic signed [12:0] settle_wheel(input longint v, input longint lim,
                                                      output logic hit);
    longint whole, rem;
    whole = v >>> SUM_SHIFT;
    rem   = v - (whole <<< SUM_SHIFT);
    hit   = 1'b1;
    if (whole > lim || (whole == lim && rem != 0)) return 13'(lim);
    if (whole < -lim) return 13'(-lim);
    hit = 1'b0;
    return 13'((v + (longint'(1) <<< (SUM_SHIFT - 1))) >>> SUM_SHIFT);
  endfunction

  function automatic wheel_set_t mix_wheels(input logic [15:0] sf, input logic [15:0] hd,
                                            input logic signed [15:0] sp,
                                            input logic [11:0] limit);
    wheel_set_t ws;
    longint     c, s, r, x, y, rot;
    logic [2:0] hit;
    turn_to_cos_sin(hd, c, s);
    r   = longint'(limit);
    x   = longint'(sf) * r * c;
    y   = longint'(sf) * r * s;
    rot = (longint'(sp) * r) <<< 32;
    ws.sf    = sf;
    ws.hd    = hd;
    ws.sp    = sp;
    ws.one   = settle_wheel((x <<< 16) + rot, r, hit[0]);
    ws.two   = settle_wheel(-(x <<< 15) - 56756 * y + rot, r, hit[1]);
    ws.three = settle_wheel(-(x <<< 15) + 56756 * y + rot, r, hit[2]);
    ws.mask  = hit;
    return ws;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // Offer one command and hold it until the transfer
  task automatic send_command(input logic [15:0] sf, input logic [15:0] hd,
                              input logic signed [15:0] sp);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    speed_fraction <= sf;
    heading        <= hd;
    spin           <= sp;
    do @(posedge clk); while (!in_ready);
    pending_wheels.push_back(mix_wheels(sf, hd, sp, top_speed));
  endtask

  // Drain the pipe, then write the register
  task automatic set_top_speed(input logic [11:0] value);
    in_valid <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    top_speed = value;
  endtask

  task automatic test_reset_speed();
    send_command(16'd0,     16'h0000, 16'sd0);
    send_command(16'd32768, 16'h0000, 16'sd0);
    send_command(16'd32768, 16'h4000, 16'sd0);
    send_command(16'd32768, 16'h8000, 16'sd0);
    send_command(16'd32768, 16'hC000, 16'sd0);
    // quadrant selection edges
    send_command(16'd32768, 16'h1FFF, 16'sd0);
    send_command(16'd32768, 16'h2000, 16'sd0);
    send_command(16'd32768, 16'hDFFF, 16'sd0);
    send_command(16'd32768, 16'hFFFF, 16'sd0);
    // exactly -R stays unclamped, spin alone
    send_command(16'd0,     16'h0000, -16'sd32768);
    send_command(16'd0,     16'h0000, 16'sd32767);
    send_command(16'd32768, 16'h0000, 16'sd32767);
    send_command(16'd32768, 16'h8000, -16'sd32768);
    // over-range magnitude
    send_command(16'hFFFF,  16'h5555, 16'sd0);
  endtask

  task automatic test_zero_top_speed();
    set_top_speed(12'd0);
    send_command(16'd32768, 16'h2AAA, 16'sd32767);
    send_command(16'hFFFF,  16'hFFFF, -16'sd32768);
    send_command(16'd0,     16'h0000, 16'sd0);
  endtask

  task automatic test_half_step_rounding();
    set_top_speed(12'd1);
    send_command(16'd0, 16'h0000, 16'sd16384);
    send_command(16'd0, 16'h0000, -16'sd16384);
    send_command(16'd0, 16'h0000, 16'sd16383);
    send_command(16'd0, 16'h0000, -16'sd16385);
  endtask

  task automatic test_full_top_speed();
    set_top_speed(12'd4095);
    send_command(16'd32768, 16'h0000, 16'sd0);
    send_command(16'hFFFF,  16'hAAAA, -16'sd32768);
    send_command(16'd32768, 16'h6000, 16'sd32767);
    send_command(16'h8001,  16'hE000, 16'sd12345);
  endtask

  task automatic test_random_mix(input logic [11:0] speed_setting, input int count);
    logic [15:0]        sf, hd;
    logic signed [15:0] sp;
    int                 pick;
    set_top_speed(speed_setting);
    for (int n = 0; n < count; n++) begin
      // alternate stretches with and without idling
      if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) sf = 16'($urandom_range(0, 32768));
      else if (pick == 7) sf = 16'd32768;
      else if (pick == 8) sf = 16'($urandom_range(32769, 65535));
      else sf = 16'($urandom_range(0, 255));
      if ($urandom_range(0, 6) == 0)
        hd = 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2);
      else
        hd = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 6) sp = 16'($signed($urandom_range(0, 16383)) - 8192);
      else if (pick < 8) sp = 16'($urandom);
      else if (pick == 8) sp = ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32768;
      else sp = 16'sd0;
      send_command(sf, hd, sp);
    end
  endtask

  // Receiver side: random stalls, drop ready while holding
  always @(posedge clk) begin
    if (!gaps_on) begin
      out_ready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else begin
      sink_hold = next_gap();
      out_ready <= (sink_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (pending_wheels.size() == 0) begin
        flag_error($sformatf("result %0d with nothing pending: %0d %0d %0d mask %b",
                             result_count, wheel_one_speed, wheel_two_speed,
                             wheel_three_speed, clamped_mask));
      end else begin
        want = pending_wheels.pop_front();
        if (wheel_one_speed !== want.one || wheel_two_speed !== want.two ||
            wheel_three_speed !== want.three || clamped_mask !== want.mask) begin
          flag_error($sformatf(
            "result %0d (sf %0d hd %h spin %0d): expected %0d %0d %0d mask %b, got %0d %0d %0d mask %b",
            result_count, want.sf, want.hd, want.sp, want.one, want.two, want.three,
            want.mask, wheel_one_speed, wheel_two_speed, wheel_three_speed,
            clamped_mask));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    cfg_wen        = 1'b0;
    cfg_wdata      = 12'd0;
    in_valid       = 1'b0;
    speed_fraction = 16'd0;
    heading        = 16'd0;
    spin           = 16'sd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_speed();
    test_zero_top_speed();
    test_half_step_rounding();
    test_full_top_speed();
    test_random_mix(12'd4095, 75);
    test_random_mix(12'd1, 75);
    test_random_mix(12'($urandom_range(2, 4094)), 75);
    test_random_mix(12'($urandom_range(2, 4094)), 75);
    test_random_mix(12'($urandom_range(2048, 4094)), 75);
    test_random_mix(12'd1000, 75);

    in_valid <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/twosm_pkg.sv
rtl/core/twosm_cordic_cell.sv
rtl/core/twosm_mix.sv
rtl/core/twosm_wheel_out.sv
rtl/core/three_wheel_omni_speed_mix_unit.sv
tb/three_wheel_omni_speed_mix_unit_test.sv
